@@ hw/rtl/biquad_lowpass_three_channel_macros.svh @@
// assertion macros for the biquad low-pass block checker
// expects signals clk and rst_n in the scope where the macros are used
`ifndef BIQUAD_LOWPASS_THREE_CHANNEL_MACROS_SVH
`define BIQUAD_LOWPASS_THREE_CHANNEL_MACROS_SVH

// same-cycle implication
`define BIQ_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("biquad check failed");

// next-cycle implication
`define BIQ_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("biquad check failed");

`endif

@@ hw/rtl/biq_pkg.sv @@
// shared types and constants for the biquad low-pass block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package biq_pkg;

    localparam int COEF_W     = 20;
    localparam int DELAY_W    = 32;
    localparam int PROD_W     = COEF_W + DELAY_W;
    localparam int CH_W       = 2;
    localparam int CFG_ADDR_W = 3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_B0     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_B1     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_B2     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_A1     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_A2     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BYPASS = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MA1,
        ST_MA2,
        ST_SA2,
        ST_RW,
        ST_MB0,
        ST_MB1,
        ST_MB2,
        ST_AB2,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        COEF_A1,
        COEF_A2,
        COEF_B0,
        COEF_B1,
        COEF_B2
    } coef_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_CLR,
        ACC_SUB,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        coef_sel_t coef_sel;
        acc_op_t   acc_op;
        logic      load_delay;
        logic      load_w;
        logic      done;
    } ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/biq_mac.sv @@
// shared multiply-accumulate unit: registered product, then accumulate
// depends on biq_pkg
`timescale 1ns / 1ps
`default_nettype none

module biq_mac
    import biq_pkg::*;
#(
    parameter int ACC_W = 53
)
(
    input  wire logic                     clk,
    input  wire acc_op_t                  acc_op,
    input  wire logic signed [COEF_W-1:0]  coef,
    input  wire logic signed [DELAY_W-1:0] operand,
    input  wire logic signed [ACC_W-1:0]   load_value,
    output logic signed [ACC_W-1:0]        acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(prod_reg);

    always_comb
    begin
        case (acc_op)
            ACC_LOAD: acc_next = load_value;
            ACC_CLR:  acc_next = '0;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= coef * operand;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

@@ hw/rtl/biq_seq.sv @@
// step sequencer driving the shared multiply-accumulate unit
// depends on biq_pkg
`timescale 1ns / 1ps
`default_nettype none

module biq_seq
    import biq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic skip,
    input  wire logic out_free,
    output logic      in_ready,
    output ctrl_t     ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = skip ? ST_DONE : ST_LOAD;
                else
                    state_next = ST_IDLE;
            end
            ST_LOAD: state_next = ST_MA1;
            ST_MA1:  state_next = ST_MA2;
            ST_MA2:  state_next = ST_SA2;
            ST_SA2:  state_next = ST_RW;
            ST_RW:   state_next = ST_MB0;
            ST_MB0:  state_next = ST_MB1;
            ST_MB1:  state_next = ST_MB2;
            ST_MB2:  state_next = ST_AB2;
            ST_AB2:  state_next = ST_DONE;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.coef_sel = COEF_A1;
        ctrl.acc_op   = ACC_HOLD;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_LOAD:
            begin
                ctrl.load_delay = 1'b1;
                ctrl.acc_op     = ACC_LOAD;
            end
            ST_MA1: ctrl.coef_sel = COEF_A1;
            ST_MA2:
            begin
                ctrl.coef_sel = COEF_A2;
                ctrl.acc_op   = ACC_SUB;
            end
            ST_SA2: ctrl.acc_op = ACC_SUB;
            ST_RW:
            begin
                ctrl.load_w = 1'b1;
                ctrl.acc_op = ACC_CLR;
            end
            ST_MB0: ctrl.coef_sel = COEF_B0;
            ST_MB1:
            begin
                ctrl.coef_sel = COEF_B1;
                ctrl.acc_op   = ACC_ADD;
            end
            ST_MB2:
            begin
                ctrl.coef_sel = COEF_B2;
                ctrl.acc_op   = ACC_ADD;
            end
            ST_AB2: ctrl.acc_op = ACC_ADD;
            ST_DONE: ctrl.done = out_free;
            default: in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/biquad_lowpass_three_channel.sv @@
// a filtered request steps through LOAD, MA1, MA2, SA2, RW, MB0, MB1, MB2, AB2 and DONE;
// a bypass goes straight to DONE; no new request is taken until DONE finds the output free;
// the five coefficient products run in series through the one multiply-accumulate unit
// a finished result waits in the output register while the next request is taken
// reset clears the sequencer, the output valid, all delay elements (to zero)
// and loads the coefficient registers with their low-pass defaults, bypass off
`timescale 1ns / 1ps
`default_nettype none

module biquad_lowpass_three_channel
    import biq_pkg::*;
#(
    parameter int CHANNELS     = 3,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration writes
    input  wire logic                           cfg_write,
    input  wire logic [CFG_ADDR_W-1:0]          cfg_addr,
    input  wire logic [COEF_W-1:0]              cfg_wdata,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [CH_W-1:0]                channel,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [CH_W-1:0]                     channel_out,
    output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);

    // index width into the per-channel delay registers
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // accumulator holds x * 2^24 plus two 20x32 products with headroom
    localparam int ACC_W = ((SAMPLE_WIDTH + 24 > 51) ? SAMPLE_WIDTH + 24 : 51) + 2;

    localparam int W_FRAC = 16;
    localparam int Y_FRAC = 24;

    localparam logic signed [ACC_W-1:0] HALF_W = ACC_W'(64'sd32768);
    localparam logic signed [ACC_W-1:0] HALF_Y = ACC_W'(64'sd8388608);
    localparam logic signed [ACC_W-1:0] W_MAX  = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] W_MIN  = ~W_MAX;
    localparam logic signed [ACC_W-1:0] S_MAX  =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] S_MIN  = ~S_MAX;

    // coefficient defaults, Q3.16
    localparam logic signed [COEF_W-1:0] B0_RST = 20'sd153;
    localparam logic signed [COEF_W-1:0] B1_RST = 20'sd306;
    localparam logic signed [COEF_W-1:0] B2_RST = 20'sd153;
    localparam logic signed [COEF_W-1:0] A1_RST = -20'sd121817;
    localparam logic signed [COEF_W-1:0] A2_RST = 20'sd56893;

    // configuration registers
    logic signed [COEF_W-1:0] coef_b0_reg;
    logic signed [COEF_W-1:0] coef_b1_reg;
    logic signed [COEF_W-1:0] coef_b2_reg;
    logic signed [COEF_W-1:0] coef_a1_reg;
    logic signed [COEF_W-1:0] coef_a2_reg;
    logic                     filter_bypass_reg;

    // current request
    logic [CH_W-1:0]                ch_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           skip_reg;
    logic [IDX_W-1:0]               idx;

    // per-channel delay elements
    logic signed [DELAY_W-1:0] delay_one_reg [CHANNELS];
    logic signed [DELAY_W-1:0] delay_two_reg [CHANNELS];

    // working copies for one filter step
    logic signed [DELAY_W-1:0] d1_reg;
    logic signed [DELAY_W-1:0] d2_reg;
    logic signed [DELAY_W-1:0] w_reg;

    // output register
    logic                           out_valid_reg;
    logic [CH_W-1:0]                channel_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;

    logic                      in_fire;
    logic                      item_skip;
    logic                      out_free;
    ctrl_t                     ctrl;
    logic signed [COEF_W-1:0]  mul_coef;
    logic signed [DELAY_W-1:0] mul_operand;
    logic signed [ACC_W-1:0]   x_ext;
    logic signed [ACC_W-1:0]   load_value;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   w_rnd;
    logic signed [ACC_W-1:0]   w_shift;
    logic signed [DELAY_W-1:0] w_sat;
    logic signed [ACC_W-1:0]   y_rnd;
    logic signed [ACC_W-1:0]   y_shift;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;

    assign in_fire   = in_valid & in_ready;
    // out-of-range channel behaves as bypass and leaves all state alone
    assign item_skip = filter_bypass_reg | (int'(channel) >= CHANNELS);
    assign out_free  = !out_valid_reg || out_ready;
    assign idx       = IDX_W'(ch_reg);

    // sequencer
    biq_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .skip     (item_skip),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    // multiplier operand select: coefficient with its matching delay or w
    always_comb
    begin
        case (ctrl.coef_sel)
            COEF_A1:
            begin
                mul_coef    = coef_a1_reg;
                mul_operand = d1_reg;
            end
            COEF_A2:
            begin
                mul_coef    = coef_a2_reg;
                mul_operand = d2_reg;
            end
            COEF_B0:
            begin
                mul_coef    = coef_b0_reg;
                mul_operand = w_reg;
            end
            COEF_B1:
            begin
                mul_coef    = coef_b1_reg;
                mul_operand = d1_reg;
            end
            COEF_B2:
            begin
                mul_coef    = coef_b2_reg;
                mul_operand = d2_reg;
            end
            default:
            begin
                mul_coef    = '0;
                mul_operand = '0;
            end
        endcase
    end

    // sample scaled to 2^-24 units as the accumulator seed
    assign x_ext      = ACC_W'(sample_reg);
    assign load_value = x_ext <<< Y_FRAC;

    biq_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk        (clk),
        .acc_op     (ctrl.acc_op),
        .coef       (mul_coef),
        .operand    (mul_operand),
        .load_value (load_value),
        .acc        (acc)
    );

    // new delay element: round to nearest (ties up) into 2^-8 units, saturate to 32 bits
    assign w_rnd   = acc + HALF_W;
    assign w_shift = w_rnd >>> W_FRAC;

    always_comb
    begin
        if (w_shift > W_MAX)
            w_sat = W_MAX[DELAY_W-1:0];
        else if (w_shift < W_MIN)
            w_sat = W_MIN[DELAY_W-1:0];
        else
            w_sat = w_shift[DELAY_W-1:0];
    end

    // output: round to nearest integer, saturate to sample width
    assign y_rnd   = acc + HALF_Y;
    assign y_shift = y_rnd >>> Y_FRAC;

    always_comb
    begin
        if (y_shift > S_MAX)
            y_sat = S_MAX[SAMPLE_WIDTH-1:0];
        else if (y_shift < S_MIN)
            y_sat = S_MIN[SAMPLE_WIDTH-1:0];
        else
            y_sat = y_shift[SAMPLE_WIDTH-1:0];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg       <= B0_RST;
            coef_b1_reg       <= B1_RST;
            coef_b2_reg       <= B2_RST;
            coef_a1_reg       <= A1_RST;
            coef_a2_reg       <= A2_RST;
            filter_bypass_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                REG_B0:     coef_b0_reg       <= cfg_wdata;
                REG_B1:     coef_b1_reg       <= cfg_wdata;
                REG_B2:     coef_b2_reg       <= cfg_wdata;
                REG_A1:     coef_a1_reg       <= cfg_wdata;
                REG_A2:     coef_a2_reg       <= cfg_wdata;
                REG_BYPASS: filter_bypass_reg <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    // request capture and the skip flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skip_reg <= item_skip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg     <= channel;
            sample_reg <= sample_in;
        end
        if (ctrl.load_delay)
        begin
            d1_reg <= delay_one_reg[idx];
            d2_reg <= delay_two_reg[idx];
        end
        if (ctrl.load_w)
        begin
            w_reg <= w_sat;
        end
    end

    // delay elements shift once per filtered request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                delay_one_reg[i] <= '0;
                delay_two_reg[i] <= '0;
            end
        end
        else if (ctrl.done && !skip_reg)
        begin
            delay_two_reg[idx] <= d1_reg;
            delay_one_reg[idx] <= w_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.done)
        begin
            channel_out_reg <= ch_reg;
            sample_out_reg  <= skip_reg ? sample_reg : y_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = channel_out_reg;
    assign sample_out  = sample_out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/biq_checker.sv @@
// port-level checks for the biquad low-pass block, bound to the top level
// depends on biq_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "biquad_lowpass_three_channel_macros.svh"

module biq_checker
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [CH_W-1:0]         channel_out,
    input wire logic [SAMPLE_WIDTH-1:0] sample_out
);

    // a stalled result holds
    `BIQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(sample_out) && $stable(channel_out))

    // one request at a time: busy right after a request is taken
    `BIQ_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // a fresh result appears only as the sequencer returns to idle
    `BIQ_ASSERT_IMP(a_result_at_idle, $rose(out_valid), in_ready)

endmodule

bind biquad_lowpass_three_channel biq_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_biq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .channel_out (channel_out),
    .sample_out  (sample_out)
);

`default_nettype wire

@@ verif/biquad_lowpass_three_channel_tb.sv @@
// self-checking testbench for the three-channel biquad low-pass block
// depends on biq_pkg and biquad_lowpass_three_channel, drives random and directed requests
`timescale 1ns / 1ps

module biquad_lowpass_three_channel_tb;
    import biq_pkg::*;

    localparam int CH_COUNT  = 3;
    localparam int SW        = 16;
    localparam int SEGMENTS  = 8;
    localparam int SEG_ITEMS = 190;

    // reset values of the coefficient registers
    localparam int DEF_B0 = 153;
    localparam int DEF_B1 = 306;
    localparam int DEF_B2 = 153;
    localparam int DEF_A1 = -121817;
    localparam int DEF_A2 = 56893;

    localparam int COEF_MAX = 524287;
    localparam int COEF_MIN = -524288;

    localparam logic signed [63:0] W_MAX   = 64'sd2147483647;
    localparam logic signed [63:0] W_MIN   = -64'sd2147483648;
    localparam logic signed [63:0] OUT_MAX = 64'sd32767;
    localparam logic signed [63:0] OUT_MIN = -64'sd32768;

    // one request or one filtered result: channel and sample
    typedef struct packed {
        logic [CH_W-1:0]      ch;
        logic signed [SW-1:0] smp;
    } axis_sample_t;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_write  = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr   = REG_B0;
    logic [COEF_W-1:0]     cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [CH_W-1:0]       channel    = '0;
    logic signed [SW-1:0]  sample_in  = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [CH_W-1:0]       channel_out;
    logic signed [SW-1:0]  sample_out;

    biquad_lowpass_three_channel #(
        .CHANNELS     (CH_COUNT),
        .SAMPLE_WIDTH (SW)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .channel_out (channel_out),
        .sample_out  (sample_out)
    );

    // shadow copy of the coefficient registers and the per-axis delay line
    logic signed [COEF_W-1:0] b0_sh, b1_sh, b2_sh, a1_sh, a2_sh;
    logic                     bypass_sh;
    logic signed [31:0]       delay_one_sh [CH_COUNT];
    logic signed [31:0]       delay_two_sh [CH_COUNT];

    axis_sample_t samples_to_send [$];
    axis_sample_t expected_filtered [$];
    axis_sample_t next_req;
    axis_sample_t got_res;
    axis_sample_t want_res;

    int  requests_issued = 0;
    int  results_seen    = 0;
    int  mismatch_count  = 0;
    int  send_idle_pct   = 7;
    int  recv_idle_pct   = 80;
    bit  req_taken       = 1'b0;

    // held level per axis, gives step-like runs so the filter settles
    logic signed [SW-1:0] held_level [CH_COUNT];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // direct-form-II step for one axis; bypass and unknown axes leave state alone
    function automatic axis_sample_t run_biquad(input axis_sample_t req);
        axis_sample_t       res;
        logic signed [63:0] x;
        logic signed [63:0] d1;
        logic signed [63:0] d2;
        logic signed [63:0] acc;
        logic signed [63:0] w;
        logic signed [63:0] y;
        res = req;
        if (bypass_sh || req.ch >= CH_COUNT)
            return res;
        x   = 64'(req.smp);
        d1  = 64'(delay_one_sh[req.ch]);
        d2  = 64'(delay_two_sh[req.ch]);
        acc = (x <<< 24) - a1_sh * d1 - a2_sh * d2;
        // round to nearest, ties upwards, then clamp to the delay width
        w = (acc + 64'sd32768) >>> 16;
        if (w > W_MAX)
            w = W_MAX;
        else if (w < W_MIN)
            w = W_MIN;
        y = b0_sh * w + b1_sh * d1 + b2_sh * d2;
        y = (y + 64'sd8388608) >>> 24;
        if (y > OUT_MAX)
            y = OUT_MAX;
        else if (y < OUT_MIN)
            y = OUT_MIN;
        delay_two_sh[req.ch] = d1[31:0];
        delay_one_sh[req.ch] = w[31:0];
        res.smp = y[SW-1:0];
        return res;
    endfunction

    // monitor: register writes, accepted requests and returned results, all at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_taken = 1'b0;
            b0_sh     = COEF_W'(DEF_B0);
            b1_sh     = COEF_W'(DEF_B1);
            b2_sh     = COEF_W'(DEF_B2);
            a1_sh     = COEF_W'(DEF_A1);
            a2_sh     = COEF_W'(DEF_A2);
            bypass_sh = 1'b0;
            for (int i = 0; i < CH_COUNT; i++)
            begin
                delay_one_sh[i] = '0;
                delay_two_sh[i] = '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_addr)
                    REG_B0:     b0_sh = cfg_wdata;
                    REG_B1:     b1_sh = cfg_wdata;
                    REG_B2:     b2_sh = cfg_wdata;
                    REG_A1:     a1_sh = cfg_wdata;
                    REG_A2:     a2_sh = cfg_wdata;
                    REG_BYPASS: bypass_sh = cfg_wdata[0];
                    default:    ;
                endcase
            end
            // read by the driver at the next falling edge
            req_taken = in_valid && in_ready;
            if (req_taken)
                expected_filtered.push_back(run_biquad({channel, sample_in}));
            if (out_valid && out_ready)
            begin
                results_seen++;
                got_res = {channel_out, sample_out};
                if (expected_filtered.size() == 0)
                    flag_mismatch($sformatf("unexpected result ch %0d sample %0d",
                                            channel_out, sample_out));
                else
                begin
                    want_res = expected_filtered.pop_front();
                    if (got_res.ch !== want_res.ch)
                        flag_mismatch($sformatf("channel_out %0d, expected %0d",
                                                got_res.ch, want_res.ch));
                    if (got_res.smp !== want_res.smp)
                        flag_mismatch($sformatf("sample_out %0d, expected %0d (ch %0d)",
                                                got_res.smp, want_res.smp, want_res.ch));
                end
            end
        end
    end

    // driver: request side fed from the pending queue, result side stalls at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = samples_to_send.pop_front();
                    in_valid  <= 1'b1;
                    channel   <= next_req.ch;
                    sample_in <= next_req.smp;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_request(input logic [CH_W-1:0] ch, input logic signed [SW-1:0] smp);
        samples_to_send.push_back({ch, smp});
        requests_issued++;
    endtask

    // every request gives one result, so equal counts mean the block is idle
    task automatic wait_idle();
        while (results_seen != requests_issued)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_coefs(input int b0, input int b1, input int b2,
                             input int a1, input int a2, input bit byp);
        logic [COEF_W-1:0] byp_word;
        byp_word    = COEF_W'($urandom);
        byp_word[0] = byp;
        write_reg(REG_B0, b0[COEF_W-1:0]);
        write_reg(REG_B1, b1[COEF_W-1:0]);
        write_reg(REG_B2, b2[COEF_W-1:0]);
        write_reg(REG_A1, a1[COEF_W-1:0]);
        write_reg(REG_A2, a2[COEF_W-1:0]);
        // upper bits of the bypass word carry noise
        write_reg(REG_BYPASS, byp_word);
    endtask

    // mix of full-range noise, small values, rails and held steps
    function automatic logic signed [SW-1:0] pick_sample(input logic [CH_W-1:0] ch);
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return SW'($urandom);
        else if (pick < 6)
            return SW'($signed($urandom_range(400)) - 200);
        else if (pick < 7)
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else if (ch < CH_COUNT)
        begin
            if ($urandom_range(15) == 0)
                held_level[ch] = SW'($urandom);
            return held_level[ch];
        end
        else
            return SW'($urandom);
    endfunction

    initial
    begin
        logic [CH_W-1:0] ch;
        for (int i = 0; i < CH_COUNT; i++)
            held_level[i] = SW'($urandom);
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed: rails on axes 0 and 1, small values on axis 2, with reset coefficients, unknown axis passes through
        queue_request(2'd0, 16'sh7FFF);
        queue_request(2'd0, 16'sh7FFF);
        queue_request(2'd0, 16'sh7FFF);
        queue_request(2'd1, 16'sh8000);
        queue_request(2'd1, 16'sh8000);
        queue_request(2'd1, 16'sh8000);
        queue_request(2'd2, 16'sh0001);
        queue_request(2'd2, 16'shFFFF);
        queue_request(2'd2, 16'sh0000);
        queue_request(2'd3, 16'sh7FFF);
        queue_request(2'd3, 16'sh8000);
        queue_request(2'd3, 16'sh5555);
        wait_idle();

        // bypass on: samples come back as they went in, delay line must not move
        set_coefs(DEF_B0, DEF_B1, DEF_B2, DEF_A1, DEF_A2, 1'b1);
        queue_request(2'd0, 16'sh8000);
        queue_request(2'd1, 16'sh7FFF);
        queue_request(2'd2, 16'shAAAA);
        queue_request(2'd3, 16'shFFFF);
        wait_idle();
        set_coefs(DEF_B0, DEF_B1, DEF_B2, DEF_A1, DEF_A2, 1'b0);
        queue_request(2'd0, 16'sh7FFF);
        queue_request(2'd1, 16'sh8000);
        queue_request(2'd2, 16'sh5555);
        wait_idle();

        // random segments, each with its own coefficient set
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 3)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 80;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                0, 5:
                    // low-pass-like sets around the defaults
                    set_coefs($urandom_range(4000), $urandom_range(8000), $urandom_range(4000),
                              -$signed($urandom_range(126000, 60000)),
                              $urandom_range(62000, 20000), 1'b0);
                1: set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX, 1'b0);
                3: set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
                4: set_coefs($urandom, $urandom, $urandom, $urandom, $urandom, 1'b1);
                6: set_coefs(DEF_B0, DEF_B1, DEF_B2, DEF_A1, DEF_A2, 1'b0);
                default:
                    set_coefs($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
            endcase
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // out-of-range axis now and then
                ch = ($urandom_range(15) == 0) ? 2'd3 : CH_W'($urandom_range(CH_COUNT - 1));
                queue_request(ch, pick_sample(ch));
            end
            wait_idle();
        end

        // let any stray result show up before the verdict
        repeat (30) @(negedge clk);
        if (expected_filtered.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_filtered.size()));
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
